>>> hw/rtl/ohrp_pkg.sv
// ----------------------------------------------------------------------------
// ohrp_pkg
// Types and constants shared by the hex response parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ohrp_pkg;

    localparam int DIGIT_W     = 6;
    localparam int CODE_W      = 4;
    localparam int DATA_W      = 32;
    localparam int GROUP_W     = 16;
    localparam int QUEUE_DEPTH = 8;

    localparam logic [7:0] CHAR_FOUR = 8'h34;
    localparam logic [7:0] CHAR_ONE  = 8'h31;

    localparam logic [CODE_W-1:0] CODE_LIMIT_RESET = 4'd15;

    typedef enum logic [1:0] {
        KIND_VALUE = 2'd0,
        KIND_CODE  = 2'd1,
        KIND_COUNT = 2'd2
    } result_kind_t;

    typedef enum logic {
        MODE_VALUE = 1'b0,
        MODE_CODES = 1'b1
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] character;
        logic       char_valid;
        logic       mode;
        logic       end_of_response;
    } item_t;

    typedef struct packed {
        logic                in_response;
        parse_mode_t         latched_mode;
        logic [DIGIT_W-1:0]  digit_count;
        logic                first_digit_is_four;
        logic                prefix_matched;
        logic [DATA_W-1:0]   accumulator;
        logic [GROUP_W-1:0]  group_value;
        logic [CODE_W-1:0]   codes_emitted;
    } parse_state_t;

    typedef struct packed {
        result_kind_t        kind;
        logic                ok;
        logic [DATA_W-1:0]   data;
        logic [CODE_W-1:0]   count;
        logic                last;
    } result_t;

    // {is_hex, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/ohrp_step.sv
// ----------------------------------------------------------------------------
// ohrp_step
// Per-character parse step: next response state and up to two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohrp_step
    import ohrp_pkg::*;
#(
    parameter int VALUE_DIGIT_CAP = 30,
    parameter int CODE_DIGIT_CAP  = 62,
    parameter int MAX_CODES       = 15
)
(
    input  parse_state_t      state,
    input  item_t             item,
    input  logic [CODE_W-1:0] code_limit,
    output parse_state_t      state_next,
    output result_t           res0,
    output result_t           res1,
    output logic [1:0]        res_count
);

    parse_state_t      st;
    logic [4:0]        hn;
    logic              is_digit;
    logic [3:0]        d;
    logic [DIGIT_W-1:0] idx;
    logic [CODE_W-1:0] lim;
    logic              code_hit;
    logic              good;
    result_t           code_res;
    result_t           close_res;

    always_comb
    begin
        st = state;
        if (!state.in_response)
        begin
            st.latched_mode = parse_mode_t'(item.mode);
            st.in_response  = 1'b1;
        end

        hn       = hex_nibble(item.character);
        is_digit = item.char_valid & hn[4];
        d        = hn[3:0];
        idx      = st.digit_count;
        lim      = (code_limit < CODE_W'(MAX_CODES)) ? code_limit : CODE_W'(MAX_CODES);
        code_hit = 1'b0;

        if (is_digit)
        begin
            if (st.latched_mode == MODE_VALUE)
            begin
                if (idx < DIGIT_W'(VALUE_DIGIT_CAP))
                begin
                    if (idx == DIGIT_W'(0))
                        st.first_digit_is_four = (item.character == CHAR_FOUR);
                    if (idx == DIGIT_W'(1))
                        st.prefix_matched = st.first_digit_is_four &
                                            (item.character == CHAR_ONE);
                    if (st.prefix_matched && (idx == DIGIT_W'(2) || idx == DIGIT_W'(3)))
                        st.accumulator = '0;
                    else
                        st.accumulator = {st.accumulator[DATA_W-5:0], d};
                    st.digit_count = idx + DIGIT_W'(1);
                end
            end
            else
            begin
                if (idx < DIGIT_W'(CODE_DIGIT_CAP))
                begin
                    if (idx >= DIGIT_W'(2))
                    begin
                        st.group_value = {st.group_value[GROUP_W-5:0], d};
                        // group complete every fourth digit after the skipped pair
                        if (idx[1:0] == 2'd1 && st.codes_emitted < lim)
                        begin
                            code_hit         = 1'b1;
                            st.codes_emitted = st.codes_emitted + CODE_W'(1);
                        end
                    end
                    st.digit_count = idx + DIGIT_W'(1);
                end
            end
        end

        code_res       = '0;
        code_res.kind  = KIND_CODE;
        code_res.ok    = 1'b1;
        code_res.data  = DATA_W'(st.group_value);

        good = (st.digit_count >= DIGIT_W'(4)) &&
               (st.digit_count > (st.prefix_matched ? DIGIT_W'(4) : DIGIT_W'(0)));

        close_res      = '0;
        close_res.last = 1'b1;
        if (st.latched_mode == MODE_VALUE)
        begin
            close_res.kind = KIND_VALUE;
            close_res.ok   = good;
            close_res.data = good ? st.accumulator : '0;
        end
        else
        begin
            close_res.kind  = KIND_COUNT;
            close_res.ok    = 1'b1;
            close_res.count = st.codes_emitted;
        end

        res0      = code_hit ? code_res : close_res;
        res1      = close_res;
        res_count = 2'(code_hit) + 2'(item.end_of_response);

        state_next = item.end_of_response ? '0 : st;
    end

endmodule

>>> hw/rtl/ohrp_result_queue.sv
// ----------------------------------------------------------------------------
// ohrp_result_queue
// Small result FIFO taking up to two results per cycle, one out per cycle while out_pop is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohrp_result_queue
    import ohrp_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  result_t    push0,
    input  result_t    push1,
    input  logic [1:0] push_count,
    input  logic       reserve,
    output logic       can_accept,
    output logic       out_valid,
    input  logic       out_pop,
    output result_t    head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [LVL_W:0] ACCEPT_MAX = (LVL_W+1)'(DEPTH - 2);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [LVL_W-1:0]   level_reg;
    logic [LVL_W-1:0]   level_next;
    logic               pop;
    logic [LVL_W:0]     demand;

    assign out_valid = (level_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign pop       = out_valid & out_pop;

    // room must remain for the two results the stage may still push and the two the accepted character may push
    assign demand     = {1'b0, level_reg} + (reserve ? (LVL_W+1)'(2) : '0);
    assign can_accept = (demand <= ACCEPT_MAX);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        level_next  = level_reg + LVL_W'(push_count) - LVL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

>>> hw/rtl/obd_hex_response_parser.sv
// ----------------------------------------------------------------------------
// obd_hex_response_parser
// Accepted characters are registered in the stage and their results queued;
// the queue head drives the outputs. Throughput: one character per cycle,
// limited only by the result queue draining; a character that completes a
// code and also closes the response puts two results in the queue. Reset
// clears all response state, empties the queue and sets code_limit to 15.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obd_hex_response_parser
    import ohrp_pkg::*;
#(
    parameter int VALUE_DIGIT_CAP = 30,
    parameter int CODE_DIGIT_CAP  = 62,
    parameter int MAX_CODES       = 15
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CODE_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         character,
    input  logic               char_valid,
    input  logic               mode,
    input  logic               end_of_response,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         result_kind,
    output logic               ok,
    output logic [DATA_W-1:0]  data_value,
    output logic [CODE_W-1:0]  code_count,
    output logic               last_result
);

    logic [CODE_W-1:0] code_limit_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    logic              stage_valid_reg;
    item_t             stage_item_reg;
    result_t           res0;
    result_t           res1;
    logic [1:0]        res_count;
    logic [1:0]        push_count;
    logic              can_accept;
    logic              in_take;
    result_t           head;

    assign in_stall = ~can_accept;
    assign in_take  = in_valid & can_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_limit_reg <= CODE_LIMIT_RESET;
        else if (cfg_wr_en)
            code_limit_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= in_take;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            stage_item_reg <= '{character:       character,
                                char_valid:      char_valid,
                                mode:            mode,
                                end_of_response: end_of_response};
    end

    ohrp_step #(
        .VALUE_DIGIT_CAP (VALUE_DIGIT_CAP),
        .CODE_DIGIT_CAP  (CODE_DIGIT_CAP),
        .MAX_CODES       (MAX_CODES)
    ) u_step (
        .state      (state_reg),
        .item       (stage_item_reg),
        .code_limit (code_limit_reg),
        .state_next (state_next),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (stage_valid_reg)
            state_reg <= state_next;
    end

    assign push_count = stage_valid_reg ? res_count : 2'd0;

    ohrp_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (res0),
        .push1      (res1),
        .push_count (push_count),
        .reserve    (stage_valid_reg),
        .can_accept (can_accept),
        .out_valid  (out_valid),
        .out_pop    (~out_stall),
        .head       (head)
    );

    assign result_kind = head.kind;
    assign ok          = head.ok;
    assign data_value  = head.data;
    assign code_count  = head.count;
    assign last_result = head.last;

endmodule
